>>> rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// Bigram Bloom signature package
// Hash constants, index width and the types shared by the signature modules.
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int unsigned SIG_W     = 64;
    localparam int unsigned SIG_IDX_W = $clog2(SIG_W);

    localparam logic [31:0] PAIR_K1   = 32'd2654435761;
    localparam logic [31:0] PAIR_K2   = 32'd2246822519;
    localparam logic [31:0] PAIR_C2   = 32'd12345;
    localparam logic [31:0] PAIR_K3   = 32'd3266489917;
    localparam logic [31:0] PAIR_C3   = 32'd67890;

    localparam logic [31:0] SINGLE_K1 = 32'd17;
    localparam logic [31:0] SINGLE_K2 = 32'd31;
    localparam logic [31:0] SINGLE_C2 = 32'd5;
    localparam logic [31:0] SINGLE_K3 = 32'd127;
    localparam logic [31:0] SINGLE_C3 = 32'd13;

    typedef logic [SIG_W-1:0]     sig_t;
    typedef logic [SIG_IDX_W-1:0] sig_idx_t;

    // Held input item; only the low index bits of the byte reach any hash
    typedef struct packed {
        sig_idx_t byte_lo;
        logic     is_last;
        logic     is_empty;
    } item_t;

    typedef struct packed {
        logic seen_first;
        sig_t running;
    } acc_state_t;

    function automatic sig_t bit_at(input sig_idx_t idx);
        sig_t mask;
        mask      = '0;
        mask[idx] = 1'b1;
        return mask;
    endfunction

    // (x * k + c) mod 2^SIG_IDX_W
    function automatic sig_idx_t hash_idx(input sig_idx_t x, input logic [31:0] k,
                                          input logic [31:0] c);
        logic [2*SIG_IDX_W-1:0] prod;
        prod = {{SIG_IDX_W{1'b0}}, x} * {{SIG_IDX_W{1'b0}}, k[SIG_IDX_W-1:0]};
        return prod[SIG_IDX_W-1:0] + c[SIG_IDX_W-1:0];
    endfunction

endpackage

>>> rtl/bigram_bloom_signature.sv
// ----------------------------------------------------------------------------
// Bigram Bloom signature
// 64-bit Bloom signature over the byte bigrams of a string.
// ----------------------------------------------------------------------------
// The block takes one byte of a string per cycle and answers with one 64-bit
// signature when the byte marked is_last (or an is_empty item) arrives; other
// bytes give no result. An item passes an input register and then the hash
// and accumulate logic into the result register, which offers the signature.
// The input side keeps taking one item per cycle while a signature waits to
// be collected; only an item that ends a string waits for the result register
// to free.
module bigram_bloom_signature
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        is_empty,
    output logic        sig_valid,
    input  logic        sig_ready,
    output logic [63:0] signature
);

    logic                held_reg;
    logic                held_next;
    bbs_pkg::item_t      item_reg;
    bbs_pkg::item_t      item_next;
    logic                step;
    bbs_pkg::sig_t       pair_mask;
    bbs_pkg::sig_t       single_mask;
    bbs_pkg::acc_state_t acc_state;

    assign item_ready = ~held_reg | step;

    always_comb
    begin
        held_next = held_reg;
        item_next = item_reg;
        if (item_ready)
        begin
            held_next          = item_valid;
            item_next.byte_lo  = data_byte[bbs_pkg::SIG_IDX_W-1:0];
            item_next.is_last  = is_last;
            item_next.is_empty = is_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    bbs_hash u_hash
    (
        .byte_lo     (item_reg.byte_lo),
        .pair_mask   (pair_mask),
        .single_mask (single_mask)
    );

    bbs_accum u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_held   (held_reg),
        .item        (item_reg),
        .pair_mask   (pair_mask),
        .single_mask (single_mask),
        .sig_ready   (sig_ready),
        .step        (step),
        .sig_valid   (sig_valid),
        .signature   (signature),
        .acc_state   (acc_state)
    );

    a_empty_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.is_empty |=> sig_valid && signature == 64'd0)
        else $error("empty string did not give a zero signature");

    a_idle_running_clear : assert property (@(posedge clk) disable iff (!rst_n)
        !acc_state.seen_first |-> acc_state.running == 64'd0)
        else $error("running signature set with no byte held");

    a_ready_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> item_ready)
        else $error("input stalled with an empty input register");

    a_single_weight : assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.is_last && !item_reg.is_empty && !acc_state.seen_first
        |=> $countones(signature) >= 1 && $countones(signature) <= 3)
        else $error("one-byte signature has a wrong number of bits");

endmodule

>>> rtl/bbs_hash.sv
// ----------------------------------------------------------------------------
// Bigram Bloom signature hash
// Signature bit masks for a byte pair and for a lone byte.
// ----------------------------------------------------------------------------
module bbs_hash
(
    input  bbs_pkg::sig_idx_t byte_lo,
    output bbs_pkg::sig_t     pair_mask,
    output bbs_pkg::sig_t     single_mask
);

    // The bigram's low index bits are the current byte's low bits, and only
    // those bits of each product modulo 2^32 select a signature bit.
    assign pair_mask =
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::PAIR_K1, 32'd0)) |
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::PAIR_K2, bbs_pkg::PAIR_C2)) |
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::PAIR_K3, bbs_pkg::PAIR_C3));

    assign single_mask =
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::SINGLE_K1, 32'd0)) |
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::SINGLE_K2,
                                          bbs_pkg::SINGLE_C2)) |
        bbs_pkg::bit_at(bbs_pkg::hash_idx(byte_lo, bbs_pkg::SINGLE_K3,
                                          bbs_pkg::SINGLE_C3));

endmodule

>>> rtl/bbs_accum.sv
// ----------------------------------------------------------------------------
// Bigram Bloom signature accumulator
// Running signature per string and the result register.
// ----------------------------------------------------------------------------
module bbs_accum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_held,
    input  bbs_pkg::item_t      item,
    input  bbs_pkg::sig_t       pair_mask,
    input  bbs_pkg::sig_t       single_mask,
    input  logic                sig_ready,
    output logic                step,
    output logic                sig_valid,
    output bbs_pkg::sig_t       signature,
    output bbs_pkg::acc_state_t acc_state
);

    logic                seen_reg;
    logic                seen_next;
    bbs_pkg::sig_t       running_reg;
    bbs_pkg::sig_t       running_next;
    logic                sig_valid_reg;
    logic                sig_valid_next;
    bbs_pkg::sig_t       signature_reg;
    bbs_pkg::sig_t       signature_next;
    bbs_pkg::sig_t       joined;
    logic                ends;

    assign ends   = item.is_empty | item.is_last;
    assign step   = item_held & (~ends | ~sig_valid_reg | sig_ready);
    assign joined = seen_reg ? (running_reg | pair_mask) : '0;

    always_comb
    begin
        seen_next      = seen_reg;
        running_next   = running_reg;
        sig_valid_next = sig_valid_reg & ~sig_ready;
        signature_next = signature_reg;
        if (step)
        begin
            if (item.is_empty)
            begin
                seen_next      = 1'b0;
                running_next   = '0;
                sig_valid_next = 1'b1;
                signature_next = '0;
            end
            else if (item.is_last)
            begin
                seen_next      = 1'b0;
                running_next   = '0;
                sig_valid_next = 1'b1;
                signature_next = seen_reg ? joined : single_mask;
            end
            else
            begin
                seen_next    = 1'b1;
                running_next = joined;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            running_reg   <= '0;
            sig_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            running_reg   <= running_next;
            sig_valid_reg <= sig_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        signature_reg <= signature_next;
    end

    assign sig_valid            = sig_valid_reg;
    assign signature            = signature_reg;
    assign acc_state.seen_first = seen_reg;
    assign acc_state.running    = running_reg;

endmodule
